// File: rtl/core/srtf_pkg.sv
// srtf_pkg: shared widths, codes and control types for the srtf scheduler
// used by srtf_cell, srtf_scheduler and srtf_checker; no dependencies
`default_nettype none

package srtf_pkg;

   // fixed field widths
   localparam int SLOT_W     = 4;
   localparam int FIELD_W    = 16;
   localparam int NOW_W      = 17;
   localparam int CNT_W      = 5;

   // stream word widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   // saturation limits
   localparam logic [NOW_W-1:0] CLOCK_MAX = 17'h1FFFF;
   localparam logic [CNT_W-1:0] DONE_MAX  = 5'd31;

   // request kinds carried in req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic               load_en;
      logic [SLOT_W-1:0]  load_slot;
      logic [FIELD_W-1:0] load_arrival;
      logic [FIELD_W-1:0] load_burst;
      logic               dec_en;
      logic [NOW_W-1:0]   clock_time;
   } ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/srtf_scheduler.sv
// srtf_scheduler: preemptive shortest-remaining-time-first scheduler, top level
// depends on srtf_pkg and srtf_cell (one cell per process slot)
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tuser: func; tdata: slot, arrival, burst
//  rsp     | out | rsp_tvalid / rsp_tready | tuser: idle, finished; tdata: ran_slot,
//          |     |                         |        turnaround, waiting, all_done, now
//  csr     | in  | csr_wr_en               | csr_wr_data: process_count
//
// a load word goes from ST_IDLE to ST_RESULT; a tick word goes through ST_SCAN:
// the scan word walks the cell chain one slot per cycle, then ST_TURN and ST_WAIT do the
// turnaround and waiting arithmetic and ST_RESULT fills the output register.
// one word is in flight at a time; a new word is taken while a result waits.
// reset clears remaining times, clock, done count and process_count.
// a stalled rsp side holds the result register; the next result waits and blocks new words.
`default_nettype none

module srtf_scheduler
   import srtf_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int TIME_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request words
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // slot[3:0], arrival[19:4], burst[35:20]
   input  wire logic                  req_tuser,  // func[0]
   // result words
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // ran_slot[3:0], turnaround[20:4],
                                                  // waiting[37:21], all_done[38], now[55:39]
   output logic [RSP_USER_W-1:0]      rsp_tuser,  // idle[0], finished[1]
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CNT_W-1:0]      csr_wr_data // process_count
);

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TURN,
      ST_WAIT,
      ST_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NOW_W-1:0]     clock_ff, clock_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic [SLOT_W-1:0]    ran_ff, ran_in;
   logic                 idle_ff, idle_in;
   logic                 fin_ff, fin_in;
   logic [NOW_W-1:0]     tat_ff, tat_in;
   logic [NOW_W-1:0]     wt_ff, wt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                 accept;
   logic                 scan_end;
   logic                 rsp_free;
   logic [NOW_W-1:0]     clock_next;
   ctrl_type             ctrl;

   // scan chain taps
   logic                 chain_go    [MAX_PROCESSES+1];
   logic                 chain_found [MAX_PROCESSES+1];
   logic [IDX_W-1:0]     chain_idx   [MAX_PROCESSES+1];
   logic [TIME_BITS-1:0] chain_rem   [MAX_PROCESSES+1];
   logic [TIME_BITS-1:0] chain_arr   [MAX_PROCESSES+1];
   logic [TIME_BITS-1:0] chain_bur   [MAX_PROCESSES+1];

   // handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign scan_end   = (state_ff == ST_SCAN) && chain_go[MAX_PROCESSES];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign clock_next = (clock_ff == CLOCK_MAX) ? CLOCK_MAX : clock_ff + NOW_W'(1);

   // broadcast to the cells
   assign ctrl.load_en      = accept && (req_tuser == FUNC_LOAD);
   assign ctrl.load_slot    = req_tdata[3:0];
   assign ctrl.load_arrival = req_tdata[19:4];
   assign ctrl.load_burst   = req_tdata[35:20];
   assign ctrl.dec_en       = scan_end && chain_found[MAX_PROCESSES];
   assign ctrl.clock_time   = clock_ff;

   // head of the chain: empty candidate
   assign chain_go[0]    = accept && (req_tuser == FUNC_TICK);
   assign chain_found[0] = 1'b0;
   assign chain_idx[0]   = '0;
   assign chain_rem[0]   = '0;
   assign chain_arr[0]   = '0;
   assign chain_bur[0]   = '0;

   // one cell per process slot
   for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
      srtf_cell #(
         .INDEX     (g),
         .IDX_W     (IDX_W),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .dec_idx       (chain_idx[MAX_PROCESSES]),
         .process_count (count_ff),
         .go_i          (chain_go[g]),
         .found_i       (chain_found[g]),
         .idx_i         (chain_idx[g]),
         .rem_i         (chain_rem[g]),
         .arr_i         (chain_arr[g]),
         .bur_i         (chain_bur[g]),
         .go_o          (chain_go[g+1]),
         .found_o       (chain_found[g+1]),
         .idx_o         (chain_idx[g+1]),
         .rem_o         (chain_rem[g+1]),
         .arr_o         (chain_arr[g+1]),
         .bur_o         (chain_bur[g+1])
      );
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      clock_in     = clock_ff;
      done_in      = done_ff;
      ran_in       = ran_ff;
      idle_in      = idle_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;
      wt_in        = wt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == FUNC_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  ran_in   = '0;
                  idle_in  = 1'b1;
                  fin_in   = 1'b0;
                  tat_in   = '0;
                  wt_in    = '0;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               ran_in   = chain_found[MAX_PROCESSES] ?
                          SLOT_W'(chain_idx[MAX_PROCESSES]) : '0;
               idle_in  = !chain_found[MAX_PROCESSES];
               fin_in   = chain_found[MAX_PROCESSES] &&
                          (chain_rem[MAX_PROCESSES] == TIME_BITS'(1));
               clock_in = clock_next;
               if (chain_found[MAX_PROCESSES] &&
                   (chain_rem[MAX_PROCESSES] == TIME_BITS'(1)) &&
                   (done_ff != DONE_MAX)) begin
                  done_in = done_ff + CNT_W'(1);
               end
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            // clock_ff now holds the completion time
            if (fin_ff && (CMP_W'(clock_ff) >= CMP_W'(chain_arr[MAX_PROCESSES]))) begin
               tat_in = NOW_W'(CMP_W'(clock_ff) - CMP_W'(chain_arr[MAX_PROCESSES]));
            end else begin
               tat_in = '0;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (fin_ff && (CMP_W'(tat_ff) >= CMP_W'(chain_bur[MAX_PROCESSES]))) begin
               wt_in = NOW_W'(CMP_W'(tat_ff) - CMP_W'(chain_bur[MAX_PROCESSES]));
            end else begin
               wt_in = '0;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {clock_ff, (done_ff >= count_ff), wt_ff, tat_ff, ran_ff};
               rsp_user_in  = {fin_ff, idle_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         clock_ff     <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clock_ff     <= clock_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ran_ff      <= ran_in;
      idle_ff     <= idle_in;
      fin_ff      <= fin_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// File: rtl/core/srtf_cell.sv
// srtf_cell: one process slot plus one stage of the min-remaining scan chain
// depends on srtf_pkg (ctrl_type, widths)
`default_nettype none

module srtf_cell
   import srtf_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int IDX_W     = 4,
   parameter int TIME_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_type             ctrl,
   input  wire logic [IDX_W-1:0]     dec_idx,
   input  wire logic [CNT_W-1:0]     process_count,
   // candidate from the previous cell
   input  wire logic                 go_i,
   input  wire logic                 found_i,
   input  wire logic [IDX_W-1:0]     idx_i,
   input  wire logic [TIME_BITS-1:0] rem_i,
   input  wire logic [TIME_BITS-1:0] arr_i,
   input  wire logic [TIME_BITS-1:0] bur_i,
   // candidate to the next cell
   output logic                      go_o,
   output logic                      found_o,
   output logic [IDX_W-1:0]          idx_o,
   output logic [TIME_BITS-1:0]      rem_o,
   output logic [TIME_BITS-1:0]      arr_o,
   output logic [TIME_BITS-1:0]      bur_o
);

   localparam int CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

   logic [TIME_BITS-1:0] arrival_ff, arrival_in;
   logic [TIME_BITS-1:0] burst_ff, burst_in;
   logic [TIME_BITS-1:0] remain_ff, remain_in;
   logic                 go_ff;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] arr_ff, arr_in;
   logic [TIME_BITS-1:0] bur_ff, bur_in;

   logic load_hit;
   logic dec_hit;
   logic eligible;
   logic take;

   // slot hit decode and eligibility of this slot
   assign load_hit = ctrl.load_en && (int'(ctrl.load_slot) == INDEX);
   assign dec_hit  = ctrl.dec_en && (dec_idx == IDX_W'(INDEX));
   assign eligible = (INDEX < int'(process_count)) && (remain_ff != '0) &&
                     (CMP_W'(arrival_ff) <= CMP_W'(ctrl.clock_time));
   // strict less keeps the lower index on a tie
   assign take     = eligible && (!found_i || (remain_ff < rem_i));

   // slot contents: load or decrement
   always_comb begin
      arrival_in = arrival_ff;
      burst_in   = burst_ff;
      remain_in  = remain_ff;
      if (load_hit) begin
         arrival_in = TIME_BITS'(ctrl.load_arrival);
         burst_in   = TIME_BITS'(ctrl.load_burst);
         remain_in  = TIME_BITS'(ctrl.load_burst);
      end else if (dec_hit) begin
         remain_in  = remain_ff - TIME_BITS'(1);
      end
   end

   // candidate stage, moves only when the scan word passes
   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      arr_in   = arr_ff;
      bur_in   = bur_ff;
      if (go_i) begin
         found_in = found_i || take;
         idx_in   = take ? IDX_W'(INDEX) : idx_i;
         rem_in   = take ? remain_ff : rem_i;
         arr_in   = take ? arrival_ff : arr_i;
         bur_in   = take ? burst_ff : bur_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         go_ff     <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         go_ff     <= go_i;
      end
      arrival_ff <= arrival_in;
      burst_ff   <= burst_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      arr_ff     <= arr_in;
      bur_ff     <= bur_in;
   end

   assign go_o    = go_ff;
   assign found_o = found_ff;
   assign idx_o   = idx_ff;
   assign rem_o   = rem_ff;
   assign arr_o   = arr_ff;
   assign bur_o   = bur_ff;

endmodule

`default_nettype wire

// File: rtl/core/srtf_checker.sv
// srtf_checker: port-level assertions for srtf_scheduler, bound to the top level
// depends on srtf_pkg (stream widths)
`default_nettype none

module srtf_checker
   import srtf_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one word at a time: ready drops after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // idle or load words carry no slot and no times
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && (rsp_tdata[37:0] == '0))
      else $error("idle word reports a run");

   // waiting never exceeds turnaround
   a_wait_le_tat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[37:21] <= rsp_tdata[20:4])
      else $error("waiting above turnaround");

   // turnaround never exceeds the completion time
   a_tat_le_now: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[20:4] <= rsp_tdata[55:39])
      else $error("turnaround above current time");

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
